// ----- rtl/gbdet_pkg.sv -----
package gbdet_pkg;

   localparam int unsigned CNT_W     = 16;
   localparam int unsigned COUNT_MAX = 65535;

   localparam logic [7:0] ASCII_LIM   = 8'h80;
   localparam logic [7:0] LEAD_LO     = 8'hA1;
   localparam logic [7:0] LEAD_HI     = 8'hF7;
   localparam logic [7:0] TRAIL_LO    = 8'hA1;
   localparam logic [7:0] TRAIL_HI    = 8'hFE;
   localparam logic [7:0] SYMBOL_LO   = 8'hA1;
   localparam logic [7:0] SYMBOL_HI   = 8'hA9;
   localparam logic [7:0] COMMON_LO   = 8'hB0;
   localparam logic [7:0] COMMON_HI   = 8'hD7;
   localparam logic [7:0] RARE_LO     = 8'hD8;
   localparam logic [7:0] RARE_HI     = 8'hF7;

   typedef logic [CNT_W-1:0] count_type;

   typedef struct packed {
      logic ascii;
      logic symbol;
      logic common;
      logic rare;
      logic invalid;
      logic pend_set;
      logic pend_clr;
   } bump_type;

   typedef struct packed {
      count_type ascii;
      count_type symbol;
      count_type common;
      count_type rare;
      count_type invalid;
      count_type total;
   } totals_type;

   function automatic count_type sat_inc(count_type c, logic b);
      count_type r;
      r = c;
      if (b && (c < count_type'(COUNT_MAX))) begin
         r = c + count_type'(1);
      end
      return r;
   endfunction

endpackage

// ----- rtl/gbdet_classify.sv -----
module gbdet_classify
   import gbdet_pkg::*;
(
   input  logic       pending,
   input  logic [7:0] lead,
   input  logic [7:0] data,
   output bump_type   bump
);

   logic trail_ok;

   assign trail_ok = (data >= TRAIL_LO) && (data <= TRAIL_HI);

   always_comb begin
      bump = '0;
      if (pending) begin
         bump.pend_clr = 1'b1;
         if (trail_ok) begin
            if (lead >= SYMBOL_LO && lead <= SYMBOL_HI) begin
               bump.symbol = 1'b1;
            end else if (lead >= COMMON_LO && lead <= COMMON_HI) begin
               bump.common = 1'b1;
            end else if (lead >= RARE_LO && lead <= RARE_HI) begin
               bump.rare = 1'b1;
            end else begin
               bump.invalid = 1'b1;
            end
         end else begin
            // drop the bad trail byte, count the pair as invalid
            bump.invalid = 1'b1;
         end
      end else if (data >= LEAD_LO && data <= LEAD_HI) begin
         bump.pend_set = 1'b1;
      end else if (data < ASCII_LIM) begin
         bump.ascii = 1'b1;
      end
   end

endmodule

// ----- rtl/gbdet_tally.sv -----
module gbdet_tally
   import gbdet_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data,
   input  logic       last,
   output totals_type tot_next,
   output logic       guess
);

   logic       pending_ff, pending_in;
   logic [7:0] lead_ff, lead_in;
   totals_type tot_ff, tot_in;
   bump_type   bump;

   logic [CNT_W:0]   common2;
   logic [CNT_W:0]   cr_sum;
   logic [CNT_W+1:0] cr2;

   gbdet_classify u_classify (
      .pending (pending_ff),
      .lead    (lead_ff),
      .data    (data),
      .bump    (bump)
   );

   always_comb begin
      tot_next.total   = sat_inc(tot_ff.total, 1'b1);
      tot_next.ascii   = sat_inc(tot_ff.ascii, bump.ascii);
      tot_next.symbol  = sat_inc(tot_ff.symbol, bump.symbol);
      tot_next.common  = sat_inc(tot_ff.common, bump.common);
      tot_next.rare    = sat_inc(tot_ff.rare, bump.rare);
      tot_next.invalid = sat_inc(tot_ff.invalid, bump.invalid);
   end

   assign common2 = {tot_next.common, 1'b0};
   assign cr_sum  = {1'b0, tot_next.common} + {1'b0, tot_next.rare};
   assign cr2     = {cr_sum, 1'b0};
   assign guess   = (common2 > {1'b0, tot_next.total}) || (cr2 > {2'b00, tot_next.total});

   always_comb begin
      pending_in = pending_ff;
      lead_in    = lead_ff;
      tot_in     = tot_ff;
      if (step) begin
         if (last) begin
            // buffer done: start the next one from zero
            pending_in = 1'b0;
            lead_in    = '0;
            tot_in     = '0;
         end else begin
            tot_in = tot_next;
            if (bump.pend_set) begin
               pending_in = 1'b1;
               lead_in    = data;
            end else if (bump.pend_clr) begin
               pending_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         lead_ff    <= '0;
         tot_ff     <= '0;
      end else begin
         pending_ff <= pending_in;
         lead_ff    <= lead_in;
         tot_ff     <= tot_in;
      end
   end

endmodule

// ----- rtl/gb2312_text_encoding_detector.sv -----
// Channel   Direction  Handshake          Payload
// req       in         req_valid/stall    req_data_byte, req_last_byte
// rsp       out        rsp_valid/stall    rsp_guess_yes, rsp_*_count
//
// One byte per cycle while no held result stalls the pipe. A byte goes into
// the input register, is then classified and counted, and on the last byte
// the counts and guess land in the result register.
// Synchronous active-high reset clears the pending lead and all counters.
// A held result stalls the whole pipe; otherwise req_stall stays low.
module gb2312_text_encoding_detector
   import gbdet_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_data_byte,
   input  logic             req_last_byte,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_guess_yes,
   output logic [CNT_W-1:0] rsp_ascii_count,
   output logic [CNT_W-1:0] rsp_symbol_count,
   output logic [CNT_W-1:0] rsp_common_count,
   output logic [CNT_W-1:0] rsp_rare_count,
   output logic [CNT_W-1:0] rsp_invalid_count
);

   logic       advance;
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_data_ff;
   logic       s1_last_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       guess_ff;
   totals_type rsp_tot_ff;
   totals_type tot_next;
   logic       guess;
   logic       step;

   // hold everything while a result waits
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign step      = advance && s1_valid_ff;

   gbdet_tally u_tally (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .data     (s1_data_ff),
      .last     (s1_last_ff),
      .tot_next (tot_next),
      .guess    (guess)
   );

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         s1_valid_in  = req_valid;
         rsp_valid_in = s1_valid_ff && s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_data_ff <= req_data_byte;
         s1_last_ff <= req_last_byte;
      end
      if (step && s1_last_ff) begin
         rsp_tot_ff <= tot_next;
         guess_ff   <= guess;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_guess_yes     = guess_ff;
   assign rsp_ascii_count   = rsp_tot_ff.ascii;
   assign rsp_symbol_count  = rsp_tot_ff.symbol;
   assign rsp_common_count  = rsp_tot_ff.common;
   assign rsp_rare_count    = rsp_tot_ff.rare;
   assign rsp_invalid_count = rsp_tot_ff.invalid;

endmodule

// ----- verif/gb2312_tally_checker.sv -----
module gb2312_tally_checker
   import gbdet_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  logic [7:0]       req_data_byte,
   input  logic             req_last_byte,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  logic             rsp_guess_yes,
   input  logic [CNT_W-1:0] rsp_ascii_count,
   input  logic [CNT_W-1:0] rsp_symbol_count,
   input  logic [CNT_W-1:0] rsp_common_count,
   input  logic [CNT_W-1:0] rsp_rare_count,
   input  logic [CNT_W-1:0] rsp_invalid_count,
   output int               mismatches,
   output int               waiting
);

   typedef struct packed {
      logic      guess;
      count_type ascii;
      count_type symbol;
      count_type common;
      count_type rare;
      count_type invalid;
   } tally_type;

   tally_type  expected_tallies[$];
   logic       lead_waiting;
   logic [7:0] lead_byte;
   count_type  ascii_total;
   count_type  symbol_total;
   count_type  common_total;
   count_type  rare_total;
   count_type  invalid_total;
   count_type  byte_total;

   initial begin
      mismatches = 0;
      waiting = 0;
   end

   function automatic count_type bumped(input count_type c);
      return (c == count_type'(COUNT_MAX)) ? c : c + count_type'(1);
   endfunction

   task automatic clear_tallies();
      lead_waiting = 1'b0;
      lead_byte = 8'h00;
      ascii_total = '0;
      symbol_total = '0;
      common_total = '0;
      rare_total = '0;
      invalid_total = '0;
      byte_total = '0;
   endtask

   task automatic report(input string field, input int got, input int want);
      $display("mismatch %s: got %0d, expected %0d", field, got, want);
      mismatches++;
   endtask

   task automatic absorb_byte(input logic [7:0] b, input logic last);
      tally_type t;
      byte_total = bumped(byte_total);
      if (lead_waiting) begin
         if (b >= TRAIL_LO && b <= TRAIL_HI) begin
            if (lead_byte >= SYMBOL_LO && lead_byte <= SYMBOL_HI) begin
               symbol_total = bumped(symbol_total);
            end else if (lead_byte >= COMMON_LO && lead_byte <= COMMON_HI) begin
               common_total = bumped(common_total);
            end else if (lead_byte >= RARE_LO && lead_byte <= RARE_HI) begin
               rare_total = bumped(rare_total);
            end else begin
               invalid_total = bumped(invalid_total);
            end
         end else begin
            // bad trail: count the pair as invalid and drop the byte
            invalid_total = bumped(invalid_total);
         end
         lead_waiting = 1'b0;
      end else if (b >= LEAD_LO && b <= LEAD_HI) begin
         lead_waiting = 1'b1;
         lead_byte = b;
      end else if (b < ASCII_LIM) begin
         ascii_total = bumped(ascii_total);
      end
      if (last) begin
         t.guess = (2 * int'(common_total) > int'(byte_total)) ||
                   (2 * (int'(common_total) + int'(rare_total)) > int'(byte_total));
         t.ascii = ascii_total;
         t.symbol = symbol_total;
         t.common = common_total;
         t.rare = rare_total;
         t.invalid = invalid_total;
         expected_tallies.push_back(t);
         clear_tallies();
      end
   endtask

   always @(posedge clock) begin : scoreboard
      tally_type want;
      if (reset) begin
         clear_tallies();
         expected_tallies.delete();
      end else begin
         // predict first so that any latency lines up
         if (req_valid && !req_stall) begin
            absorb_byte(req_data_byte, req_last_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_tallies.size() == 0) begin
               report("unexpected result", 1, 0);
            end else begin
               want = expected_tallies.pop_front();
               if (rsp_guess_yes !== want.guess)
                  report("guess_yes", rsp_guess_yes, want.guess);
               if (rsp_ascii_count !== want.ascii)
                  report("ascii_count", rsp_ascii_count, want.ascii);
               if (rsp_symbol_count !== want.symbol)
                  report("symbol_count", rsp_symbol_count, want.symbol);
               if (rsp_common_count !== want.common)
                  report("common_count", rsp_common_count, want.common);
               if (rsp_rare_count !== want.rare)
                  report("rare_count", rsp_rare_count, want.rare);
               if (rsp_invalid_count !== want.invalid)
                  report("invalid_count", rsp_invalid_count, want.invalid);
            end
         end
      end
      waiting = expected_tallies.size();
   end

endmodule

// ----- verif/gb2312_text_encoding_detector_test.sv -----
module gb2312_text_encoding_detector_test;
   import gbdet_pkg::*;

   typedef enum logic [2:0] {
      KIND_ASCII,
      KIND_SYMBOL,
      KIND_COMMON,
      KIND_RARE,
      KIND_BAD_LEAD,
      KIND_BAD_TRAIL,
      KIND_STRAY,
      KIND_NOISE
   } text_kind_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [7:0]       req_data_byte = 8'h00;
   logic             req_last_byte = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic             rsp_guess_yes;
   logic [CNT_W-1:0] rsp_ascii_count;
   logic [CNT_W-1:0] rsp_symbol_count;
   logic [CNT_W-1:0] rsp_common_count;
   logic [CNT_W-1:0] rsp_rare_count;
   logic [CNT_W-1:0] rsp_invalid_count;
   int               mismatches;
   int               waiting;
   bit               idle_on = 1'b1;
   int               bytes_sent = 0;

   gb2312_text_encoding_detector dut (.*);

   gb2312_tally_checker checker_inst (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // {is_pair, first byte, second byte}; single-byte items use only the low byte
   function automatic logic [16:0] make_token(input text_kind_type kind);
      logic [7:0] trail;
      trail = 8'($urandom_range(TRAIL_LO, TRAIL_HI));
      case (kind)
         KIND_ASCII: return {1'b0, 8'h00, 8'($urandom_range(0, ASCII_LIM - 1))};
         KIND_SYMBOL: return {1'b1, 8'($urandom_range(SYMBOL_LO, SYMBOL_HI)), trail};
         KIND_COMMON: return {1'b1, 8'($urandom_range(COMMON_LO, COMMON_HI)), trail};
         KIND_RARE: return {1'b1, 8'($urandom_range(RARE_LO, RARE_HI)), trail};
         KIND_BAD_LEAD: return {1'b1, 8'($urandom_range(SYMBOL_HI + 1, COMMON_LO - 1)), trail};
         KIND_BAD_TRAIL: begin
            trail = ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom_range(0, TRAIL_LO - 1));
            return {1'b1, 8'($urandom_range(LEAD_LO, LEAD_HI)), trail};
         end
         KIND_STRAY: begin
            if ($urandom_range(0, 1) == 0)
               return {1'b0, 8'h00, 8'($urandom_range(ASCII_LIM, LEAD_LO - 1))};
            return {1'b0, 8'h00, 8'($urandom_range(LEAD_HI + 1, 8'hFF))};
         end
         default: return {1'b0, 8'h00, 8'($urandom())};
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data_byte = b;
      req_last_byte = last;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_token(input text_kind_type kind, input logic last);
      logic [16:0] token;
      token = make_token(kind);
      if (token[16]) send_byte(token[15:8], 1'b0);
      send_byte(token[7:0], last);
   endtask

   // hold the sender until every pending result is out
   task automatic drain();
      req_valid = 1'b0;
      wait (waiting == 0);
      @(negedge clock);
   endtask

   initial begin : rsp_back_pressure
      int burst;
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 16);
            rsp_stall = 1'b1;
            repeat (burst) @(negedge clock);
            rsp_stall = 1'b0;
         end else if (idle_on && $urandom_range(0, 63) == 0) begin
            repeat ($urandom_range(40, 160)) @(negedge clock);
         end
      end
   end

   initial begin : stimulus
      text_kind_type lean;
      int            tokens;
      bit            lone_lead;
      int            random_start;
      int            buffers;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // ASCII bounds and stray high bytes
      send_byte(8'h00, 1'b0); send_byte(8'h7F, 1'b0); send_byte(8'h80, 1'b0);
      send_byte(8'hA0, 1'b0); send_byte(8'hF8, 1'b0); send_byte(8'hFF, 1'b1);
      // symbol bounds, lead in the unassigned gap
      send_byte(8'hA1, 1'b0); send_byte(8'hA1, 1'b0); send_byte(8'hA9, 1'b0);
      send_byte(8'hFE, 1'b0); send_byte(8'hAA, 1'b0); send_byte(8'hA1, 1'b1);
      // hanzi bounds; the guess sits exactly on its threshold
      send_byte(8'hB0, 1'b0); send_byte(8'hA1, 1'b0); send_byte(8'hD7, 1'b0);
      send_byte(8'hFE, 1'b0); send_byte(8'hD8, 1'b0); send_byte(8'hA1, 1'b0);
      send_byte(8'hF7, 1'b0); send_byte(8'hFE, 1'b1);
      // bad trails on both sides, then a lone lead on the last byte
      send_byte(8'hA1, 1'b0); send_byte(8'hA0, 1'b0); send_byte(8'hB0, 1'b0);
      send_byte(8'hFF, 1'b0); send_byte(8'h41, 1'b0); send_byte(8'hF7, 1'b1);
      drain();

      idle_on = 1'b1;
      random_start = bytes_sent;
      buffers = 0;
      while (bytes_sent - random_start < 1500) begin
         if (bytes_sent - random_start > 1200) idle_on = 1'b0;
         lean = text_kind_type'($urandom_range(0, 7));
         tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         lone_lead = ($urandom_range(0, 7) == 0);
         for (int i = 0; i < tokens; i++) begin
            send_token($urandom_range(0, 1) ? lean : text_kind_type'($urandom_range(0, 7)),
                       !lone_lead && i == tokens - 1);
         end
         if (lone_lead) send_byte(8'($urandom_range(LEAD_LO, LEAD_HI)), 1'b1);
         buffers++;
         if (buffers == 30) drain();
      end

      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && waiting == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin : watchdog
      #30_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
